// ===== src/dsrv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and functions for the dual-slot record validator.
// No dependencies; imported by the top level and by its checker.

package dsrv_pkg;

    // Record layout and CRC constants.
    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [16:0] HEADER_BYTES   = 17'd12;
    localparam logic [16:0] CRC_BYTES      = 17'd4;
    localparam logic [15:0] LEGACY_VERSION = 16'd1;

    // Register reset values.
    localparam logic [15:0] CUR_VERSION_RST = 16'd2;
    localparam logic [7:0]  CUR_LEN_RST     = 8'd32;
    localparam logic [7:0]  LEGACY_LEN_RST  = 8'd24;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_CUR_VERSION = 2'd0,
        REG_CUR_LEN     = 2'd1,
        REG_LEGACY_LEN  = 2'd2
    } reg_index_t;

    // Verdict codes, in falling order of priority after the OK code.
    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_READ       = 3'd1,
        ERR_MAGIC      = 3'd2,
        ERR_VERSION    = 3'd3,
        ERR_CRC_BEYOND = 3'd4,
        ERR_CRC        = 3'd5
    } err_code_t;

    // Magic word "BMRC", one byte per offset.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h42;
            2'd1:    val = 8'h4D;
            2'd2:    val = 8'h52;
            default: val = 8'h43;
        endcase
        return val;
    endfunction

    // One byte of the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
        end
        return crc;
    endfunction

endpackage

// ===== src/dual_slot_record_validator.sv =====
`timescale 1ns / 1ps
// Dual-slot record validator: per-record checking and slot selection.
// Depends on dsrv_pkg.

// The block takes one record byte per beat and sustains one beat per clock
// unless in_stall holds it; the byte-wide CRC-32 update, which sits between
// the record state registers and themselves, sets that figure. Non-final
// bytes give no result. The last byte of a record (offset RECORD_BYTES-1) is
// captured into a snapshot register; its result beat is then loaded into
// the result register, from which it is presented. It carries the verdict
// for the record together with the updated load slot, save slot and next
// generation over both slots. The slot tag of the last byte alone decides
// which slot the verdict is filed under. The configuration registers may be
// written only while no record result is still in flight.

module dual_slot_record_validator #(
    parameter int RECORD_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        slot,
    input  logic [7:0]  record_byte,
    input  logic        read_error,
    // Result beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic        done_slot,
    output logic        record_valid,
    output logic [2:0]  error_code,
    output logic [31:0] record_generation,
    output logic        any_valid,
    output logic        load_slot,
    output logic        save_slot,
    output logic [31:0] next_generation,
    output logic        save_blocked,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import dsrv_pkg::*;

    localparam logic [7:0]  LAST_OFFSET = 8'(RECORD_BYTES - 1);
    localparam logic [16:0] RECORD_LEN  = 17'(RECORD_BYTES);

    // Configuration registers
    logic [15:0] cur_version_reg;
    logic [7:0]  cur_len_reg;
    logic [7:0]  legacy_len_reg;
    logic        cfg_write;

    // Per-record state
    logic [7:0]  offset_reg,  offset_next;
    logic [31:0] crc_reg,     crc_next;
    logic        magic_reg,   magic_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] plen_reg,    plen_next;
    logic [31:0] gen_reg,     gen_next;
    logic [31:0] stored_reg,  stored_next;
    logic        pend_reg,    pend_next;

    // Snapshot of a finished record
    logic        snap_valid_reg;
    logic        snap_slot_reg;
    logic [31:0] snap_crc_reg;
    logic        snap_magic_reg;
    logic [15:0] snap_version_reg;
    logic [15:0] snap_plen_reg;
    logic [31:0] snap_gen_reg;
    logic [31:0] snap_stored_reg;
    logic        snap_pend_reg;

    // Per-slot history
    logic [1:0]  slot_valid_reg,  slot_valid_next;
    logic [31:0] slot_gen_reg [2];
    logic [31:0] slot_gen_next [2];
    logic [1:0]  slot_fail_reg,   slot_fail_next;

    // Result register
    logic        out_valid_reg;
    logic        out_slot_reg;
    logic        out_rvalid_reg;
    err_code_t   out_err_reg;
    logic [31:0] out_rgen_reg;
    logic        out_any_reg;
    logic        out_load_reg;
    logic        out_save_reg;
    logic [31:0] out_ngen_reg;
    logic        out_blocked_reg;

    // Handshake and datapath wires
    logic        in_fire;
    logic        last_byte;
    logic        out_load_ok;
    logic        snap_fire;
    logic [16:0] crc_off;
    logic [16:0] off_wide;
    logic [16:0] crc_idx;
    err_code_t   err;
    logic        rec_ok;
    logic        size_ok;
    logic        sec_newer;
    logic [31:0] gen_diff;
    logic        sel_load;
    logic        sel_save;
    logic [31:0] sel_ngen;

    // ---------------------------------------------------------------
    // Configuration port: zero-wait writes, reads straight from registers.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_version_reg <= CUR_VERSION_RST;
            cur_len_reg     <= CUR_LEN_RST;
            legacy_len_reg  <= LEGACY_LEN_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_CUR_VERSION: cur_version_reg <= pwdata[15:0];
                REG_CUR_LEN:     cur_len_reg     <= pwdata[7:0];
                REG_LEGACY_LEN:  legacy_len_reg  <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_CUR_VERSION: prdata = {16'd0, cur_version_reg};
            REG_CUR_LEN:     prdata = {24'd0, cur_len_reg};
            REG_LEGACY_LEN:  prdata = {24'd0, legacy_len_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Flow control: the snapshot stage drains into the result register.
    // ---------------------------------------------------------------
    assign out_load_ok = !out_valid_reg || !out_stall;
    assign snap_fire   = snap_valid_reg && out_load_ok;
    assign in_stall    = snap_valid_reg && !out_load_ok;
    assign in_fire     = in_valid && !in_stall;
    assign last_byte   = (offset_reg == LAST_OFFSET);

    // ---------------------------------------------------------------
    // Record state update for one byte.
    // ---------------------------------------------------------------
    assign off_wide = {9'd0, offset_reg};
    assign crc_off  = HEADER_BYTES + {1'b0, plen_reg};
    assign crc_idx  = off_wide - crc_off;

    always_comb
    begin
        pend_next    = pend_reg | read_error;
        magic_next   = magic_reg;
        version_next = version_reg;
        plen_next    = plen_reg;
        gen_next     = gen_reg;
        crc_next     = crc_reg;
        stored_next  = stored_reg;
        offset_next  = offset_reg + 8'd1;

        // Header fields by offset.
        case (offset_reg) inside
            [8'd0:8'd3]:
            begin
                if (record_byte != magic_byte(offset_reg[1:0]))
                begin
                    magic_next = 1'b0;
                end
            end
            8'd4:  version_next[7:0]   = record_byte;
            8'd5:  version_next[15:8]  = record_byte;
            8'd6:  plen_next[7:0]      = record_byte;
            8'd7:  plen_next[15:8]     = record_byte;
            8'd8:  gen_next[7:0]       = record_byte;
            8'd9:  gen_next[15:8]      = record_byte;
            8'd10: gen_next[23:16]     = record_byte;
            8'd11: gen_next[31:24]     = record_byte;
            default: ;
        endcase

        // Header and payload feed the CRC; the four bytes after them
        // hold the stored CRC, little endian.
        if (off_wide < crc_off)
        begin
            crc_next = crc_byte(crc_reg, record_byte);
        end
        else if (off_wide < crc_off + CRC_BYTES)
        begin
            stored_next[{crc_idx[1:0], 3'b000} +: 8] = record_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= 8'd0;
            crc_reg     <= CRC_ALL_ONES;
            magic_reg   <= 1'b1;
            version_reg <= 16'd0;
            plen_reg    <= 16'd0;
            gen_reg     <= 32'd0;
            stored_reg  <= 32'd0;
            pend_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            if (last_byte)
            begin
                offset_reg  <= 8'd0;
                crc_reg     <= CRC_ALL_ONES;
                magic_reg   <= 1'b1;
                version_reg <= 16'd0;
                plen_reg    <= 16'd0;
                gen_reg     <= 32'd0;
                stored_reg  <= 32'd0;
                pend_reg    <= 1'b0;
            end
            else
            begin
                offset_reg  <= offset_next;
                crc_reg     <= crc_next;
                magic_reg   <= magic_next;
                version_reg <= version_next;
                plen_reg    <= plen_next;
                gen_reg     <= gen_next;
                stored_reg  <= stored_next;
                pend_reg    <= pend_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Snapshot of a finished record.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (in_fire && last_byte)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_fire)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last_byte)
        begin
            snap_slot_reg    <= slot;
            snap_crc_reg     <= crc_next;
            snap_magic_reg   <= magic_next;
            snap_version_reg <= version_next;
            snap_plen_reg    <= plen_next;
            snap_gen_reg     <= gen_next;
            snap_stored_reg  <= stored_next;
            snap_pend_reg    <= pend_next;
        end
    end

    // ---------------------------------------------------------------
    // Verdict, in order of priority.
    // ---------------------------------------------------------------
    assign size_ok =
        (snap_version_reg == LEGACY_VERSION && snap_plen_reg == {8'd0, legacy_len_reg}) ||
        (snap_version_reg == cur_version_reg && snap_plen_reg == {8'd0, cur_len_reg});

    always_comb
    begin
        if (snap_pend_reg)
        begin
            err = ERR_READ;
        end
        else if (!snap_magic_reg)
        begin
            err = ERR_MAGIC;
        end
        else if (!size_ok)
        begin
            err = ERR_VERSION;
        end
        else if (HEADER_BYTES + {1'b0, snap_plen_reg} + CRC_BYTES > RECORD_LEN)
        begin
            err = ERR_CRC_BEYOND;
        end
        else if ((snap_crc_reg ^ CRC_ALL_ONES) != snap_stored_reg)
        begin
            err = ERR_CRC;
        end
        else
        begin
            err = ERR_OK;
        end
    end

    assign rec_ok = (err == ERR_OK);

    // ---------------------------------------------------------------
    // Slot history and wrap-aware selection of load and save slots.
    // ---------------------------------------------------------------
    always_comb
    begin
        slot_valid_next  = slot_valid_reg;
        slot_fail_next   = slot_fail_reg;
        slot_gen_next[0] = slot_gen_reg[0];
        slot_gen_next[1] = slot_gen_reg[1];
        slot_valid_next[snap_slot_reg] = rec_ok;
        slot_fail_next[snap_slot_reg]  = snap_pend_reg;
        slot_gen_next[snap_slot_reg]   = rec_ok ? snap_gen_reg : 32'd0;
    end

    assign gen_diff  = slot_gen_next[1] - slot_gen_next[0];
    assign sec_newer = (gen_diff != 32'd0) && !gen_diff[31];

    always_comb
    begin
        sel_load = 1'b0;
        sel_save = 1'b0;
        sel_ngen = 32'd1;
        if (slot_valid_next[0] && slot_valid_next[1])
        begin
            sel_load = sec_newer;
            sel_save = !sec_newer;
            sel_ngen = (sec_newer ? slot_gen_next[1] : slot_gen_next[0]) + 32'd1;
        end
        else if (slot_valid_next[0])
        begin
            sel_save = 1'b1;
            sel_ngen = slot_gen_next[0] + 32'd1;
        end
        else if (slot_valid_next[1])
        begin
            sel_load = 1'b1;
            sel_ngen = slot_gen_next[1] + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg  <= 2'b00;
            slot_fail_reg   <= 2'b00;
            slot_gen_reg[0] <= 32'd0;
            slot_gen_reg[1] <= 32'd0;
        end
        else if (snap_fire)
        begin
            slot_valid_reg  <= slot_valid_next;
            slot_fail_reg   <= slot_fail_next;
            slot_gen_reg[0] <= slot_gen_next[0];
            slot_gen_reg[1] <= slot_gen_next[1];
        end
    end

    // ---------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_ok)
        begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_fire)
        begin
            out_slot_reg    <= snap_slot_reg;
            out_rvalid_reg  <= rec_ok;
            out_err_reg     <= err;
            out_rgen_reg    <= rec_ok ? snap_gen_reg : 32'd0;
            out_any_reg     <= |slot_valid_next;
            out_load_reg    <= sel_load;
            out_save_reg    <= sel_save;
            out_ngen_reg    <= sel_ngen;
            out_blocked_reg <= |slot_fail_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign done_slot         = out_slot_reg;
    assign record_valid      = out_rvalid_reg;
    assign error_code        = out_err_reg;
    assign record_generation = out_rgen_reg;
    assign any_valid         = out_any_reg;
    assign load_slot         = out_load_reg;
    assign save_slot         = out_save_reg;
    assign next_generation   = out_ngen_reg;
    assign save_blocked      = out_blocked_reg;

endmodule

// ===== src/dsrv_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the dual-slot record validator, with its bind.
// Depends on dsrv_pkg and on the top level's port names.

module dsrv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        done_slot,
    input logic        record_valid,
    input logic [2:0]  error_code,
    input logic [31:0] record_generation,
    input logic        any_valid,
    input logic        load_slot,
    input logic        save_slot,
    input logic [31:0] next_generation,
    input logic        save_blocked
);

    import dsrv_pkg::*;

    // A stalled result beat holds its verdict.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(error_code)
            && $stable(record_generation) && $stable(done_slot))
        else $error("result beat changed while stalled");

    // Valid flag agrees with the code, and invalid records report generation 0.
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (record_valid == (error_code == ERR_OK))
            && (record_valid || record_generation == 32'd0))
        else $error("verdict fields disagree");

    // A valid record always leaves at least one valid slot and distinct load and save slots.
    a_any: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_valid |-> any_valid && save_slot != load_slot)
        else $error("valid record without a valid slot");

    // With no valid slot the selection falls back to its defaults.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !any_valid |-> !load_slot && !save_slot
            && next_generation == 32'd1)
        else $error("wrong selection with no valid slot");

    // A read error on this record blocks saving.
    a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_READ |-> save_blocked)
        else $error("read error did not block saving");

endmodule

bind dual_slot_record_validator dsrv_checker u_dsrv_checker (.*);
